/* hdl/assert_macros.svh */
// assertion macros shared by the rtl files
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is low
`define SWM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that must never hold
`define SWM_ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  `SWM_ASSERT(lbl, clk, rst_n, !(prop), msg)

`endif

/* hdl/swm_pkg.sv */
// shared constants, types and codes of the sliding window minimizer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package swm_pkg;

  // sizes
  localparam int MaxWindow  = 32;
  localparam int OffsetBits = 32;
  localparam int ValW       = 60;
  localparam int KmerDigits = 18;
  localparam int CodeW      = 7;
  localparam int KlenW      = 5;
  localparam int WlenW      = 6;
  localparam int DigW       = 2;
  localparam int CfgAddrW   = 2;
  localparam int CfgDataW   = 6;
  localparam int CntW       = $clog2(MaxWindow + 1);
  localparam int StepW      = ($clog2(MaxWindow) > $clog2(KmerDigits)) ?
                              $clog2(MaxWindow) : $clog2(KmerDigits);

  // k-mer length limits
  localparam logic [KlenW-1:0] KmerMaxOne = KlenW'(18);
  localparam logic [KlenW-1:0] KmerMaxTwo = KlenW'(9);

  // code clamps and divide-by-ten reciprocal
  localparam logic [CodeW-1:0] MaxCodeOne = CodeW'(9);
  localparam logic [CodeW-1:0] MaxCodeTwo = CodeW'(99);
  localparam int               TenRecip   = 205;
  localparam int               TenShift   = 11;

  typedef struct packed {
    logic [ValW-1:0]       val;
    logic [OffsetBits-1:0] off;
  } entry_t;

  // seed for the minimum wave: larger than any k-mer value
  localparam entry_t SeedBest = '{val: '1, off: '0};

  typedef struct packed {
    logic shift;
    logic in_win;
  } cell_ctrl_t;

  typedef struct packed {
    logic load;
    logic restart;
    logic step;
  } kmer_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_INSERT,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_KMER_LENGTH   = 2'd0,
    CFG_WINDOW_LENGTH = 2'd1,
    CFG_CODE_DIGITS   = 2'd2
  } cfg_idx_e;

endpackage

/* hdl/sliding_window_minimizer.sv */
// Sliding window k-mer minimizer. Each input beat brings one mapped symbol
// code and a start flag; the last kmer_length codes, each written with
// code_digits decimal digits, form one decimal k-mer value, and every
// complete k-mer enters a window of window_length - kmer_length + 1 k-mers, at most MaxWindow.
// Once the window is full each new k-mer yields one output beat with the
// leftmost smallest k-mer and its start position, unless that position
// equals the one last reported. The block takes one beat at a time: a beat
// whose k-mer is not yet complete is only taken in, one that completes a
// k-mer passes through the decimal-to-binary pass of the k-mer builder and
// is inserted into the window, and one that reports then also waits for the
// minimum wave to run through the chain of window cells; the report
// waits further while the output register still holds an untaken beat. A
// new input beat is taken while a finished result waits at the output.
// Configuration is written through cfg_we_i/cfg_addr_i/cfg_wdata_i; the
// user must write it only while the block is idle, which the block does not enforce;
// depends on swm_pkg, swm_cell, swm_kmer and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sliding_window_minimizer
  import swm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // symbol beats
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CodeW-1:0]      symbol_code_i,
  input  logic                  start_of_sequence_i,
  // minimizer beats
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OffsetBits-1:0] minimizer_offset_o,
  output logic [ValW-1:0]       minimizer_value_o,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CfgAddrW-1:0]   cfg_addr_i,
  input  logic [CfgDataW-1:0]   cfg_wdata_i
);

  // configuration registers
  logic [KlenW-1:0] kmer_length_q;
  logic [WlenW-1:0] window_length_q;
  logic [DigW-1:0]  code_digits_q;

  // effective settings
  logic             two_digits;
  logic [KlenW-1:0] k_eff;
  logic [WlenW:0]   w_raw;
  logic [CntW-1:0]  w_eff;

  // stream state
  state_e                state_q, state_d;
  logic [StepW-1:0]      step_q, step_d;
  logic [OffsetBits-1:0] pos_q, pos_base, off_q, off_d;
  logic [KlenW-1:0]      filled_q, filled_base, filled_new;
  logic [CntW-1:0]       count_q, count_d, count_keep;
  logic [OffsetBits-1:0] last_q;
  logic                  emitted_q;

  // output register
  logic                  out_valid_q;
  logic [OffsetBits-1:0] out_off_q;
  logic [ValW-1:0]       out_val_q;

  // control
  logic       accept;
  logic       shift_en;
  logic       load_out;
  logic       dup;
  kmer_ctrl_t kctrl;
  logic [ValW-1:0] kmer_value;

  // cell chain wiring
  entry_t new_entry;
  entry_t entry_chain [MaxWindow];
  entry_t best_chain  [MaxWindow];
  entry_t best;

  // ---------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_length_q   <= KlenW'(3);
      window_length_q <= WlenW'(8);
      code_digits_q   <= DigW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_KMER_LENGTH:   kmer_length_q   <= cfg_wdata_i[KlenW-1:0];
        CFG_WINDOW_LENGTH: window_length_q <= cfg_wdata_i[WlenW-1:0];
        CFG_CODE_DIGITS:   code_digits_q   <= cfg_wdata_i[DigW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // effective k-mer length, digit count and window size in k-mers
  // ---------------------------------------------------------------------
  always_comb begin
    // digit count 0 acts as 1, 3 acts as 2
    two_digits = code_digits_q[1];
    priority if (kmer_length_q == '0) begin
      k_eff = KlenW'(1);
    end else if (kmer_length_q > KmerMaxOne) begin
      k_eff = KmerMaxOne;
    end else begin
      k_eff = kmer_length_q;
    end
    if (two_digits && (k_eff > KmerMaxTwo)) begin
      k_eff = KmerMaxTwo;
    end
    // a window shorter than the k-mer holds a single k-mer
    if ((window_length_q >= WlenW'(kmer_length_q)) && (window_length_q >= WlenW'(k_eff))) begin
      w_raw = (WlenW+1)'(window_length_q - WlenW'(k_eff)) + (WlenW+1)'(1);
    end else begin
      w_raw = (WlenW+1)'(1);
    end
    if (int'(w_raw) > MaxWindow) begin
      w_eff = CntW'(MaxWindow);
    end else begin
      w_eff = CntW'(w_raw);
    end
  end

  // ---------------------------------------------------------------------
  // per-beat bookkeeping
  // ---------------------------------------------------------------------
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    pos_base    = start_of_sequence_i ? '0 : pos_q;
    filled_base = start_of_sequence_i ? '0 : filled_q;
    // symbols since start saturate at the longest k-mer
    filled_new  = (filled_base < KmerMaxOne) ? filled_base + KlenW'(1) : filled_base;
    // k-mer starts k-1 symbols before this one, wrapping
    off_d       = pos_base - OffsetBits'(k_eff - KlenW'(1));
    // drop oldest entries until the new one fits
    count_keep  = (count_q >= w_eff) ? w_eff - CntW'(1) : count_q;
    count_d     = count_keep + CntW'(1);
  end

  assign best = best_chain[MaxWindow-1];
  assign dup  = emitted_q && (best.off == last_q);

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    kctrl    = '0;
    shift_en = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          kctrl.load    = 1'b1;
          kctrl.restart = start_of_sequence_i;
          // no k-mer until enough symbols since start
          if (filled_new >= k_eff) begin
            state_d = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        kctrl.step = 1'b1;
        if (step_q == StepW'(KmerDigits - 1)) begin
          state_d = ST_INSERT;
        end
      end
      ST_INSERT: begin
        shift_en = 1'b1;
        state_d  = (count_d < w_eff) ? ST_IDLE : ST_SCAN;
      end
      ST_SCAN: begin
        // wave advances one cell per cycle to reach the chain end
        if (step_q == StepW'(MaxWindow - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (dup) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (((state_q == ST_CONV) && (state_d == ST_CONV)) ||
        ((state_q == ST_SCAN) && (state_d == ST_SCAN))) begin
      step_d = step_q + StepW'(1);
    end else begin
      step_d = '0;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // ---------------------------------------------------------------------
  // stream state and output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      filled_q    <= '0;
      count_q     <= '0;
      last_q      <= '0;
      emitted_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pos_q    <= pos_base + OffsetBits'(1);
        filled_q <= filled_new;
        if (start_of_sequence_i) begin
          count_q   <= '0;
          last_q    <= '0;
          emitted_q <= 1'b0;
        end
      end
      if (shift_en) begin
        count_q <= count_d;
      end
      if (load_out) begin
        last_q    <= best.off;
        emitted_q <= 1'b1;
      end
      out_valid_q <= load_out || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      off_q <= off_d;
    end
    if (load_out) begin
      out_off_q <= best.off;
      out_val_q <= best.val;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign minimizer_offset_o = out_off_q;
  assign minimizer_value_o  = out_val_q;

  // ---------------------------------------------------------------------
  // k-mer builder
  // ---------------------------------------------------------------------
  swm_kmer u_kmer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (kctrl),
    .symbol_code_i (symbol_code_i),
    .two_digits_i  (two_digits),
    .kmer_len_i    (k_eff),
    .kmer_value_o  (kmer_value)
  );

  // ---------------------------------------------------------------------
  // window as a chain of cells: cell 0 newest, cell count-1 oldest; the
  // running minimum walks from newest to oldest, one cell per cycle
  // ---------------------------------------------------------------------
  assign new_entry = '{val: kmer_value, off: off_q};

  for (genvar i = 0; i < MaxWindow; i++) begin : g_cell
    cell_ctrl_t cctrl;
    entry_t     entry_in;
    entry_t     best_in;

    assign cctrl.shift  = shift_en;
    assign cctrl.in_win = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign entry_in = new_entry;
      assign best_in  = SeedBest;
    end else begin : g_body
      assign entry_in = entry_chain[i-1];
      assign best_in  = best_chain[i-1];
    end

    swm_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cctrl),
      .entry_i (entry_in),
      .best_i  (best_in),
      .entry_o (entry_chain[i]),
      .best_o  (best_chain[i])
    );
  end

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  `SWM_ASSERT(a_conv_needs_kmer, clk_i, rst_ni, (state_q == ST_CONV) |-> (filled_q >= k_eff), "k-mer conversion without enough symbols")
  `SWM_ASSERT(a_emit_window_full, clk_i, rst_ni, (state_q == ST_EMIT) |-> (count_q >= w_eff), "report from a window that is not full")
  `SWM_ASSERT(a_report_tracked, clk_i, rst_ni, $rose(out_valid_o) |-> (emitted_q && (last_q == minimizer_offset_o)), "reported offset not recorded")
  `SWM_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CntW'(MaxWindow), "window count beyond chain length")

endmodule

/* hdl/swm_cell.sv */
// one window cell: holds a k-mer entry and a stage of the minimum wave
// depends on swm_pkg
`timescale 1ns / 1ps

module swm_cell
  import swm_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     entry_i,
  input  entry_t     best_i,
  output entry_t     entry_o,
  output entry_t     best_o
);

  entry_t entry_q;
  entry_t best_q, best_d;

  // ties go to this cell, which is older than every cell before it
  always_comb begin
    if (ctrl_i.in_win && (entry_q.val <= best_i.val)) begin
      best_d = entry_q;
    end else begin
      best_d = best_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      entry_q <= entry_i;
    end
    best_q <= best_d;
  end

  assign entry_o = entry_q;
  assign best_o  = best_q;

endmodule

/* hdl/swm_kmer.sv */
// k-mer builder: clamps the code, keeps the k-mer as decimal digits and
// converts it to binary one digit a cycle; depends on swm_pkg
`timescale 1ns / 1ps

module swm_kmer
  import swm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kmer_ctrl_t       ctrl_i,
  input  logic [CodeW-1:0] symbol_code_i,
  input  logic             two_digits_i,
  input  logic [KlenW-1:0] kmer_len_i,
  output logic [ValW-1:0]  kmer_value_o
);

  logic [KmerDigits-1:0][3:0] bcd_q, bcd_d, base, masked;
  logic [KmerDigits-1:0][3:0] conv_q;
  logic [CodeW-1:0]           code_lim, code_c, tens_x10;
  logic [CodeW+7:0]           prod;
  logic [3:0]                 tens, ones;
  logic [KlenW-1:0]           keep;
  logic [ValW-1:0]            acc_q;

  always_comb begin
    code_lim = two_digits_i ? MaxCodeTwo : MaxCodeOne;
    code_c   = (symbol_code_i > code_lim) ? code_lim : symbol_code_i;
    // tens by reciprocal, exact for codes up to 99
    prod     = (CodeW+8)'(code_c) * (CodeW+8)'(TenRecip);
    tens     = prod[TenShift +: 4];
    tens_x10 = (CodeW'(tens) << 3) + (CodeW'(tens) << 1);
    ones     = 4'(code_c - tens_x10);
    // digits kept from the previous k-mer
    if (two_digits_i) begin
      keep = KlenW'((kmer_len_i - KlenW'(1)) << 1);
    end else begin
      keep = kmer_len_i - KlenW'(1);
    end
    base = ctrl_i.restart ? '0 : bcd_q;
    for (int j = 0; j < KmerDigits; j++) begin
      masked[j] = (KlenW'(j) < keep) ? base[j] : 4'd0;
    end
    if (two_digits_i) begin
      bcd_d = {masked[KmerDigits-3:0], tens, ones};
    end else begin
      bcd_d = {masked[KmerDigits-2:0], ones};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcd_q <= '0;
    end else if (ctrl_i.load) begin
      bcd_q <= bcd_d;
    end
  end

  // horner pass, most significant digit first
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      conv_q <= bcd_d;
      acc_q  <= '0;
    end else if (ctrl_i.step) begin
      acc_q  <= (acc_q << 3) + (acc_q << 1) + ValW'(conv_q[KmerDigits-1]);
      conv_q <= {conv_q[KmerDigits-2:0], 4'd0};
    end
  end

  assign kmer_value_o = acc_q;

endmodule
